FILE: rtl/core/acg_pkg.sv
// shared types and constants for the astable/monostable clock generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package acg_pkg;

  // word layout
  localparam int IN_W      = 16;   // input word, padded to whole bytes
  localparam int OUT_W     = 32;   // result word
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 10;

  // field widths
  localparam int SAMPLE_W  = 12;
  localparam int FREQ_W    = 10;
  localparam int TIME_W    = 10;
  localparam int DUTY_W    = 7;
  localparam int DEB_W     = 10;

  // serial arithmetic widths
  localparam int MCAND_W   = 12;
  localparam int MPLR_W    = 10;
  localparam int PROD_W    = 22;

  // constants of the mapping and the period split
  localparam int CONV_SCALE = 999;
  localparam int CONV_LOW_Q = 5;     // quotient below this selects 1 Hz
  localparam int FREQ_MAX   = 1000;
  localparam int DUTY_FULL  = 100;
  localparam int DUTY_RESET = 50;
  localparam int DEB_RESET  = 200;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

endpackage

FILE: rtl/core/acg_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on acg_pkg for operand and product widths
`timescale 1ns / 1ps

module acg_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [acg_pkg::MCAND_W-1:0]  mcand,
  input  logic [acg_pkg::MPLR_W-1:0]   mplr,
  output logic                         done,
  output logic [acg_pkg::PROD_W-1:0]   product
);
  import acg_pkg::*;

  localparam int CNT_W = $clog2(MPLR_W + 1);

  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] shifted;
  logic [MPLR_W-1:0] bits;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc     <= '0;
        shifted <= PROD_W'(mcand);
        bits    <= mplr;
        cnt     <= CNT_W'(MPLR_W);
        busy    <= 1'b1;
      end else if (busy) begin
        if (bits[0]) begin
          acc <= acc + shifted;
        end
        shifted <= {shifted[PROD_W-2:0], 1'b0};
        bits    <= {1'b0, bits[MPLR_W-1:1]};
        cnt     <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

FILE: rtl/core/acg_div.sv
// restoring divider, one quotient bit per cycle
// depends on acg_pkg for the dividend width
`timescale 1ns / 1ps

module acg_div #(
  parameter int DIV_W = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [acg_pkg::PROD_W-1:0]  dividend,
  input  logic [DIV_W-1:0]            divisor,
  output logic                        done,
  output logic [acg_pkg::PROD_W-1:0]  quotient
);
  import acg_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsr;
  logic [PROD_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIV_W:0]    trial;
  logic              fits;
  logic [DIV_W:0]    diff;

  // remainder stays below the divisor, so one extra bit holds the trial value
  always_comb begin
    trial = {rem, quo[PROD_W-1]};
    fits  = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= CNT_W'(PROD_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo <= {quo[PROD_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/core/astable_monostable_clock_generator_top.sv
// top level of the astable/monostable clock generator: stream ports, config port,
// tick sequencer and generator state; uses acg_pkg, acg_mul and acg_div
`timescale 1ns / 1ps

//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  one tick word: presses and sample
//  m_        out        m_tvalid/m_tready  one result word per tick
//  cfg_      in         cfg_valid/cfg_ready register index and write data
//
// one tick word at a time; a tick with no sample and no new period runs the phase,
// tick and emit states, a sample adds a 10-step serial multiply and a 22-step
// serial divide, each with its handover, and a new period adds a divide, a
// multiply and a divide, so the length of the worst tick is set mostly by the
// shared bit-serial divider
// reset (rst, synchronous) restores the power-up mode, frequency and registers
// the next tick word is taken while the last result still waits in the output
// register; cfg_ready is always high and writes are expected only between ticks

module astable_monostable_clock_generator_top #(
  parameter int ADC_MAX          = 4095,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                           clk,
  input  logic                           rst,
  // tick word, lsb up: mode_press, step_press, sample_valid, sample_value[11:0], pad
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [acg_pkg::IN_W-1:0]       s_tdata,
  // result word, lsb up: clock_level, is_monostable, frequency_hz[9:0],
  // high_ms[9:0], low_ms[9:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [acg_pkg::OUT_W-1:0]      m_tdata,
  // register writes: 0 duty_percent, 1 debounce_ms
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [acg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acg_pkg::CFG_W-1:0]      cfg_data
);
  import acg_pkg::*;

  // divisor must hold the converter full scale and any frequency
  localparam int AdcW = $clog2(ADC_MAX + 1);
  localparam int DivW = (AdcW > FREQ_W) ? AdcW : FREQ_W;
  localparam logic [DivW-1:0]   AdcMaxDiv = DivW'(ADC_MAX);
  localparam logic [PROD_W-1:0] TpsDvd    = PROD_W'(TICKS_PER_SECOND);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV_MUL,
    S_CONV_DIV,
    S_PHASE,
    S_PER_DIV,
    S_DUTY_MUL,
    S_DUTY_DIV,
    S_TICK,
    S_EMIT
  } seq_t;

  seq_t state;

  // configuration
  logic [DUTY_W-1:0] duty;
  logic [DEB_W-1:0]  debounce;

  // generator state
  logic              mono;
  logic              pending;
  logic [FREQ_W-1:0] freq;
  logic [DEB_W-1:0]  since;
  phase_t            phase;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] lat_high;
  logic [TIME_W-1:0] lat_low;
  logic [TIME_W-1:0] period;
  logic              level;

  // serial units
  logic                mul_start;
  logic [MCAND_W-1:0]  mul_a;
  logic [MPLR_W-1:0]   mul_b;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_p;
  logic                div_start;
  logic [PROD_W-1:0]   div_n;
  logic [DivW-1:0]     div_d;
  logic                div_done;
  logic [PROD_W-1:0]   div_q;

  // tick word fields
  logic                in_mode;
  logic                in_step;
  logic                in_svalid;
  logic [SAMPLE_W-1:0] in_sample;
  logic                take;
  logic                press_ok;

  // end of high or low phase, ahead of a possible period start
  phase_t            ph1;
  logic [TIME_W-1:0] rem1;
  logic              pend1;

  logic [DUTY_W-1:0] duty_sat;
  logic [TIME_W-1:0] hi_q;

  assign in_mode   = s_tdata[0];
  assign in_step   = s_tdata[1];
  assign in_svalid = s_tdata[2];
  assign in_sample = s_tdata[3 +: SAMPLE_W];

  assign s_tready  = (state == S_IDLE);
  assign take      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign press_ok  = (in_mode || in_step) && (since >= debounce);

  assign duty_sat  = (duty > DUTY_W'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL) : duty;
  assign hi_q      = div_q[TIME_W-1:0];

  always_comb begin
    ph1   = phase;
    rem1  = rem;
    pend1 = pending;
    if (phase == PH_HIGH && rem == '0) begin
      if (!mono) begin
        ph1  = PH_LOW;
        rem1 = lat_low;
      end else begin
        pend1 = 1'b0;
        ph1   = PH_IDLE;
        rem1  = '0;
      end
    end
    if (ph1 == PH_LOW && rem1 == '0) begin
      ph1 = PH_IDLE;
    end
  end

  acg_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplr    (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  acg_div #(
    .DIV_W (DivW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      duty     <= DUTY_W'(DUTY_RESET);
      debounce <= DEB_W'(DEB_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DUTY:     duty     <= cfg_data[DUTY_W-1:0];
        CFG_DEBOUNCE: debounce <= cfg_data[DEB_W-1:0];
      endcase
    end
  end

  // tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mono      <= 1'b0;
      pending   <= 1'b1;
      freq      <= FREQ_W'(1);
      since     <= '0;
      phase     <= PH_IDLE;
      rem       <= '0;
      lat_high  <= '0;
      lat_low   <= '0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            // debounced buttons; mode press wins over step
            if (press_ok) begin
              if (in_mode) begin
                mono    <= ~mono;
                pending <= mono;
              end else if (mono) begin
                pending <= 1'b1;
              end
              since <= DEB_W'(1);
            end else if (since != '1) begin
              since <= since + 1'b1;
            end
            if (in_svalid) begin
              mul_a     <= in_sample;
              mul_b     <= MPLR_W'(CONV_SCALE);
              mul_start <= 1'b1;
              state     <= S_CONV_MUL;
            end else begin
              state <= S_PHASE;
            end
          end
        end
        S_CONV_MUL: begin
          if (mul_done) begin
            div_n     <= mul_p;
            div_d     <= AdcMaxDiv;
            div_start <= 1'b1;
            state     <= S_CONV_DIV;
          end
        end
        S_CONV_DIV: begin
          if (div_done) begin
            // conv = q + 1, capped at full scale, very low readings give 1 Hz
            if (div_q < PROD_W'(CONV_LOW_Q)) begin
              freq <= FREQ_W'(1);
            end else if (div_q >= PROD_W'(FREQ_MAX - 1)) begin
              freq <= FREQ_W'(FREQ_MAX);
            end else begin
              freq <= div_q[FREQ_W-1:0] + 1'b1;
            end
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          phase   <= ph1;
          rem     <= rem1;
          pending <= pend1;
          if (ph1 == PH_IDLE && pend1) begin
            div_n     <= TpsDvd;
            div_d     <= DivW'(freq);
            div_start <= 1'b1;
            state     <= S_PER_DIV;
          end else begin
            state <= S_TICK;
          end
        end
        S_PER_DIV: begin
          if (div_done) begin
            // long periods saturate at the 10-bit limit
            if (|div_q[PROD_W-1:TIME_W]) begin
              period <= '1;
              mul_a  <= MCAND_W'({TIME_W{1'b1}});
            end else begin
              period <= div_q[TIME_W-1:0];
              mul_a  <= MCAND_W'(div_q[TIME_W-1:0]);
            end
            mul_b     <= MPLR_W'(duty_sat);
            mul_start <= 1'b1;
            state     <= S_DUTY_MUL;
          end
        end
        S_DUTY_MUL: begin
          if (mul_done) begin
            div_n     <= mul_p;
            div_d     <= DivW'(DUTY_FULL);
            div_start <= 1'b1;
            state     <= S_DUTY_DIV;
          end
        end
        S_DUTY_DIV: begin
          if (div_done) begin
            lat_high <= hi_q;
            lat_low  <= period - hi_q;
            if (hi_q != '0) begin
              phase <= PH_HIGH;
              rem   <= hi_q;
            end else if (mono) begin
              // zero high time ends a single pulse at once
              pending <= 1'b0;
              phase   <= PH_IDLE;
              rem     <= '0;
            end else begin
              phase <= PH_LOW;
              rem   <= period - hi_q;
            end
            state <= S_TICK;
          end
        end
        S_TICK: begin
          level <= 1'b0;
          if (phase == PH_LOW && rem == '0) begin
            phase <= PH_IDLE;
          end else if (phase == PH_HIGH) begin
            level <= 1'b1;
            rem   <= rem - 1'b1;
          end else if (phase == PH_LOW) begin
            rem <= rem - 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {lat_low, lat_high, freq, mono, level};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/tb_astable_monostable_clock_generator_top.sv
// self-checking testbench for the astable/monostable clock generator top level
// drives tick words and register writes, predicts every result word and compares
// depends on acg_pkg and astable_monostable_clock_generator_top only
`timescale 1ns / 1ps

module tb_astable_monostable_clock_generator_top;
  import acg_pkg::*;

  // arithmetic of the generator as seen from outside
  localparam int unsigned RAW_FULL_SCALE = 4095;
  localparam int unsigned TICKS_PER_SEC  = 1000;
  localparam int unsigned MAP_SCALE      = 999;
  localparam int unsigned TOP_HZ         = 1000;
  localparam int unsigned FLOOR_HZ_LIMIT = 5;     // mapped values up to this give 1 Hz
  localparam int unsigned PERCENT        = 100;
  localparam int unsigned COUNT_CAP      = 1023;  // press counter and period saturate here

  // run shaping
  localparam int          RESET_CYCLES     = 11;
  localparam int          SETTLE_CYCLES    = 4;    // output register empty means the block is idle
  localparam int          TAIL_CYCLES      = 200;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          RANDOM_PHASES    = 6;
  localparam int          TICKS_PER_PHASE  = 88;
  localparam int          RUN_LIMIT_NS     = 2_000_000;

  // tick word, lsb up: mode_press, step_press, sample_valid, sample_value
  typedef struct packed {
    logic [11:0] sample_value;
    logic        sample_valid;
    logic        step_press;
    logic        mode_press;
  } tick_t;

  // result word, lsb up: clock_level, is_monostable, frequency_hz, high_ms, low_ms
  typedef struct packed {
    logic [9:0] low_ms;
    logic [9:0] high_ms;
    logic [9:0] frequency_hz;
    logic       is_monostable;
    logic       clock_level;
  } clock_out_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DUTY;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // predicted generator state and its copy of the registers
  logic [6:0]  gen_duty;
  logic [9:0]  gen_debounce;
  logic        gen_mono;
  logic        gen_pending;
  logic [9:0]  gen_freq;
  logic [9:0]  gen_since;
  phase_t      gen_phase;
  logic [9:0]  gen_remaining;
  logic [9:0]  gen_high;
  logic [9:0]  gen_low;

  clock_out_t  expected_clock_q[$];
  int unsigned mismatches      = 0;
  int unsigned burst_left      = 0;
  bit          gaps_on         = 1'b1;
  int unsigned long_holds_asked = 0;
  int unsigned long_holds_done  = 0;

  always #2 clk = ~clk;

  astable_monostable_clock_generator_top #(
    .ADC_MAX          (RAW_FULL_SCALE),
    .TICKS_PER_SECOND (TICKS_PER_SEC)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void power_up_generator();
    gen_duty      = 7'(DUTY_RESET);
    gen_debounce  = 10'(DEB_RESET);
    gen_mono      = 1'b0;
    gen_pending   = 1'b1;
    gen_freq      = 10'd1;
    gen_since     = '0;
    gen_phase     = PH_IDLE;
    gen_remaining = '0;
    gen_high      = '0;
    gen_low       = '0;
  endfunction

  // end of the high phase: astable moves to low, monostable drops the pulse
  function automatic void close_high_phase();
    if (!gen_mono) begin
      gen_phase     = PH_LOW;
      gen_remaining = gen_low;
    end else begin
      gen_pending   = 1'b0;
      gen_phase     = PH_IDLE;
      gen_remaining = '0;
    end
  endfunction

  // one millisecond tick of the generator
  function automatic clock_out_t advance_generator(tick_t t);
    clock_out_t  r;
    int unsigned mapped;
    int unsigned period;
    int unsigned duty;
    bit          take_press;

    take_press = (t.mode_press || t.step_press) && (gen_since >= gen_debounce);
    if (take_press) begin
      if (t.mode_press) begin
        gen_mono    = !gen_mono;
        gen_pending = !gen_mono;
      end else if (gen_mono) begin
        gen_pending = 1'b1;
      end
      gen_since = 10'd1;
    end else if (gen_since < COUNT_CAP) begin
      gen_since = gen_since + 10'd1;
    end

    if (t.sample_valid) begin
      mapped = int'(t.sample_value) * MAP_SCALE / RAW_FULL_SCALE + 1;
      if (mapped > TOP_HZ) mapped = TOP_HZ;
      gen_freq = (mapped <= FLOOR_HZ_LIMIT) ? 10'd1 : mapped[9:0];
    end

    if (gen_phase == PH_HIGH && gen_remaining == 0) close_high_phase();
    if (gen_phase == PH_LOW && gen_remaining == 0) gen_phase = PH_IDLE;
    if (gen_phase == PH_IDLE && gen_pending) begin
      period = TICKS_PER_SEC / ((gen_freq == 0) ? 1 : int'(gen_freq));
      if (period > COUNT_CAP) period = COUNT_CAP;
      duty = (gen_duty > PERCENT) ? PERCENT : int'(gen_duty);
      gen_high      = 10'(period * duty / PERCENT);
      gen_low       = 10'(period - int'(gen_high));
      gen_phase     = PH_HIGH;
      gen_remaining = gen_high;
      if (gen_remaining == 0) close_high_phase();
    end
    if (gen_phase == PH_LOW && gen_remaining == 0) gen_phase = PH_IDLE;

    r.clock_level = 1'b0;
    if (gen_phase == PH_HIGH) begin
      r.clock_level = 1'b1;
      gen_remaining = gen_remaining - 10'd1;
    end else if (gen_phase == PH_LOW) begin
      gen_remaining = gen_remaining - 10'd1;
    end
    r.is_monostable = gen_mono;
    r.frequency_hz  = gen_freq;
    r.high_ms       = gen_high;
    r.low_ms        = gen_low;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tick_t make_tick(bit mode, bit step, bit sv, int unsigned raw);
    tick_t t;
    t.mode_press   = mode;
    t.step_press   = step;
    t.sample_valid = sv;
    t.sample_value = raw[11:0];
    return t;
  endfunction

  // mostly fast frequencies so that many periods run, a few slow ones
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned pick;
    t.mode_press   = ($urandom_range(0, 99) < 8);
    t.step_press   = ($urandom_range(0, 99) < 20);
    t.sample_valid = ($urandom_range(0, 99) < 35);
    pick = $urandom_range(0, 9);
    if (pick < 7)      t.sample_value = 12'($urandom_range(1000, 4095));
    else if (pick < 9) t.sample_value = 12'($urandom_range(100, 999));
    else               t.sample_value = 12'($urandom_range(0, 4095));
    return t;
  endfunction

  // offers one tick word, in bursts with random gaps, and books its result
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(0, 7);
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    s_tdata  <= {1'b0, t};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_clock_q.push_back(advance_generator(t));
  endtask

  // stop offering and wait for every booked result word
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_clock_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes both registers back to back; only called with the block idle
  task automatic program_registers(input int unsigned duty, input int unsigned debounce);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DUTY;
    cfg_data  <= duty[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= debounce[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    gen_duty     = duty[6:0];
    gen_debounce = debounce[9:0];
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string field, logic [9:0] want, logic [9:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    clock_out_t want;
    clock_out_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen = clock_out_t'(m_tdata);
      if (expected_clock_q.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = expected_clock_q.pop_front();
        compare_field("clock_level", 10'(want.clock_level), 10'(seen.clock_level));
        compare_field("is_monostable", 10'(want.is_monostable), 10'(seen.is_monostable));
        compare_field("frequency_hz", want.frequency_hz, seen.frequency_hz);
        compare_field("high_ms", want.high_ms, seen.high_ms);
        compare_field("low_ms", want.low_ms, seen.low_ms);
      end
    end
  end

  // receiver: switches at random among four stall patterns, long hold on request
  initial begin
    int unsigned cyc;
    int unsigned style;
    cyc   = 0;
    style = 0;
    forever begin
      @(posedge clk);
      if (long_holds_asked != long_holds_done) begin
        long_holds_done++;
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (cyc % 64 == 0) style = $urandom_range(0, 3);
      case (style)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          m_tready <= (cyc % 4 != 0);
        end
        default: begin
          m_tready <= (cyc % 5 == 0);
        end
      endcase
      cyc++;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // power-up registers: presses too early for the debounce count are dropped,
  // a sample on the first tick already sets the first period (zero high time)
  task automatic test_power_up();
    send_tick(make_tick(1, 1, 1, 4095));
    send_tick(make_tick(0, 1, 0, 0));
    send_tick(make_tick(0, 0, 0, 2730));
  endtask

  // every press accepted: mode change mid-period, step lost in a high phase,
  // both buttons at once, step in astable
  task automatic test_buttons();
    drain_results();
    program_registers(PERCENT, 0);
    send_tick(make_tick(0, 0, 1, 1365));
    send_tick(make_tick(1, 0, 0, 0));
    send_tick(make_tick(0, 1, 0, 0));
    send_tick(make_tick(0, 0, 0, 0));
    send_tick(make_tick(0, 1, 0, 0));
    send_tick(make_tick(1, 1, 0, 0));
    send_tick(make_tick(0, 1, 0, 0));
    send_tick(make_tick(1, 0, 0, 0));
  endtask

  // presses at counts one and two are refused, the third is taken
  task automatic test_debounce_timing();
    drain_results();
    program_registers(DUTY_RESET, 3);
    repeat (3) send_tick(make_tick(0, 1, 0, 0));
  endtask

  // monostable and idle: sample extremes and both sides of the 1 Hz floor
  task automatic test_sample_mapping();
    send_tick(make_tick(0, 0, 1, 0));
    send_tick(make_tick(0, 0, 1, 20));
    send_tick(make_tick(0, 0, 1, 21));
    send_tick(make_tick(0, 0, 1, 2730));
    send_tick(make_tick(0, 0, 1, 1365));
    send_tick(make_tick(0, 0, 1, 4095));
  endtask

  // pulses with zero high time and with duty above full scale
  task automatic test_duty_extremes();
    drain_results();
    program_registers(0, 0);
    send_tick(make_tick(0, 1, 0, 0));
    drain_results();
    program_registers(127, 0);
    send_tick(make_tick(0, 1, 0, 0));
  endtask

  // receiver holds off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    drain_results();
    long_holds_asked++;
    gaps_on = 1'b0;
    repeat (12) send_tick(random_tick());
    drain_results();
    gaps_on = 1'b1;
  endtask

  // random ticks over several register settings; the last uses the longest debounce
  task automatic test_random_ticks();
    int unsigned duty;
    int unsigned debounce;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case ($urandom_range(0, 3))
        0:       duty = 0;
        1:       duty = PERCENT;
        2:       duty = 127;
        default: duty = $urandom_range(1, 99);
      endcase
      if (ph == RANDOM_PHASES - 1)          debounce = COUNT_CAP;
      else if ($urandom_range(0, 3) == 0)   debounce = 0;
      else                                  debounce = $urandom_range(1, 12);
      program_registers(duty, debounce);
      gaps_on = (ph % 3 != 2);
      repeat (TICKS_PER_PHASE) send_tick(random_tick());
    end
  endtask

  initial begin
    power_up_generator();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_power_up();
    test_buttons();
    test_debounce_timing();
    test_sample_mapping();
    test_duty_extremes();
    test_backpressure();
    test_random_ticks();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_clock_q.size() != 0) begin
      $display("%0t ns: result words missing, expected %0d more, actual 0",
               $time, expected_clock_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_astable_monostable_clock_generator_top: clean");
    end else begin
      $display("tb_astable_monostable_clock_generator_top: errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_astable_monostable_clock_generator_top: errors");
    $finish;
  end

endmodule

FILE: astable_monostable_clock_generator_top.f
rtl/core/acg_pkg.sv
rtl/core/acg_mul.sv
rtl/core/acg_div.sv
rtl/core/astable_monostable_clock_generator_top.sv
tb/sv/tb_astable_monostable_clock_generator_top.sv
